// ===== sv/page_frame_bitmap_tracker_unit_defines.svh =====
// Assertion macros shared by the page frame bitmap tracker RTL.
// Each macro takes a label, the property terms and a message.
`ifndef PAGE_FRAME_BITMAP_TRACKER_UNIT_DEFINES_SVH
`define PAGE_FRAME_BITMAP_TRACKER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define PFBT_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define PFBT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PFBT_ASSERT_IMPLY(lbl, ante, cons, msg)
`define PFBT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/pfbt_pkg.sv =====
`timescale 1ns / 1ps

package pfbt_pkg;

    localparam int ADDR_W     = 48;
    localparam int PAGE_SHIFT = 12;
    localparam int COUNT_W    = 17;
    localparam int CFG_W      = 17;
    localparam int CNT_W      = 32;
    localparam int WORD_W     = 32;
    localparam int BIT_W      = 5;

    typedef enum logic [1:0] {
        CMD_FREE      = 2'd0,
        CMD_LOCK      = 2'd1,
        CMD_UNRESERVE = 2'd2,
        CMD_RESERVE   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]         command;
        logic [ADDR_W-1:0]  address;
        logic [COUNT_W-1:0] page_count;
    } t_req;

    typedef struct packed {
        logic [CNT_W-1:0]   free_pages;
        logic [CNT_W-1:0]   used_pages;
        logic [CNT_W-1:0]   reserved_pages;
        logic [COUNT_W-1:0] pages_changed;
        logic               out_of_range;
    } t_rsp;

endpackage

// ===== sv/pfbt_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module pfbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/page_frame_bitmap_tracker_unit.sv =====
// A request with a zero count or a first page beyond the map finishes in the accept
// cycle; any other walks the map one page per cycle to its last page or the map end.
// A new request is taken only once the last response has entered the output register.
// Reset: synchronous, active low; counters clear, then a clearing pass writes every
// map row to zero while requests are stalled.
`timescale 1ns / 1ps
`include "page_frame_bitmap_tracker_unit_defines.svh"

module page_frame_bitmap_tracker_unit #(
    parameter int NUM_PAGES = 65536
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pfbt_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       i_req_valid,
    output logic                       o_req_stall,
    input  pfbt_pkg::t_req             i_req,
    output logic                       o_rsp_valid,
    input  logic                       i_rsp_stall,
    output pfbt_pkg::t_rsp             o_rsp
);

    // The page map lives in a RAM of 32-bit rows; bit k of row r is page 32 * r + k.
    localparam int ROWS    = (NUM_PAGES + pfbt_pkg::WORD_W - 1) / pfbt_pkg::WORD_W;
    localparam int ROW_W   = $clog2(ROWS);
    localparam int IDX_W   = ROW_W + pfbt_pkg::BIT_W;
    localparam int FIRST_W = pfbt_pkg::ADDR_W - pfbt_pkg::PAGE_SHIFT;
    localparam int CNT_W   = pfbt_pkg::CNT_W;
    localparam int COUNT_W = pfbt_pkg::COUNT_W;
    localparam int WORD_W  = pfbt_pkg::WORD_W;
    localparam int BIT_W   = pfbt_pkg::BIT_W;

    localparam logic [FIRST_W-1:0] LIMIT_FIRST = FIRST_W'(NUM_PAGES);
    localparam logic [IDX_W:0]     LIMIT_IDX   = (IDX_W + 1)'(NUM_PAGES);
    localparam logic [ROW_W-1:0]   LAST_ROW    = ROW_W'(ROWS - 1);

    // CLEAR sweeps the map after reset. WALK handles one page per cycle,
    // writing a row back when the walk leaves it or ends. DONE holds a finished
    // response while the output register is still occupied.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_state;

    t_state                r_state;
    logic [ROW_W-1:0]      r_clr_row;
    logic [IDX_W:0]        r_idx;
    logic [COUNT_W-1:0]    r_left;
    pfbt_pkg::t_cmd        r_cmd;
    logic                  r_fresh;
    logic [WORD_W-1:0]     r_word;
    logic [CNT_W-1:0]      r_free;
    logic [CNT_W-1:0]      r_used;
    logic [CNT_W-1:0]      r_res;
    logic [COUNT_W-1:0]    r_changed;
    logic                  r_oor;
    logic                  r_rsp_valid;
    pfbt_pkg::t_rsp        r_rsp;

    logic [CNT_W-1:0]      n_free;
    logic [CNT_W-1:0]      n_used;
    logic [CNT_W-1:0]      n_res;
    logic [COUNT_W-1:0]    n_changed;
    logic                  n_oor;

    logic [FIRST_W-1:0]    w_first;
    logic                  w_first_oor;
    logic                  w_cnt_zero;
    logic                  w_accept;
    logic [WORD_W-1:0]     w_word;
    logic [WORD_W-1:0]     w_new_word;
    logic [BIT_W-1:0]      w_bit_sel;
    logic                  w_setting;
    logic                  w_flip;
    logic [IDX_W:0]        w_idx_next;
    logic                  w_last;
    logic                  w_next_oor;
    logic                  w_row_end;
    logic                  w_walk_end;
    logic                  w_fin;
    logic                  w_slot_free;
    pfbt_pkg::t_rsp        w_fin_rsp;
    logic [CNT_W-1:0]      w_sum;

    logic                  ram_we;
    logic [ROW_W-1:0]      ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;
    logic [ROW_W-1:0]      ram_raddr;
    logic [WORD_W-1:0]     ram_rdata;

    pfbt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Request decode. The first page index is the address without its page offset.
    assign w_first     = i_req.address[pfbt_pkg::ADDR_W-1:pfbt_pkg::PAGE_SHIFT];
    assign w_first_oor = w_first >= LIMIT_FIRST;
    assign w_cnt_zero  = i_req.page_count == '0;
    assign w_accept    = i_req_valid && (r_state == ST_IDLE);

    // One request is in flight at a time; only a response in DONE blocks acceptance.
    assign o_req_stall = r_state != ST_IDLE;

    // The first page of a row comes straight from the RAM read port; later pages of
    // the same row use the locally modified copy, so no stale row is ever re-read.
    assign w_word     = r_fresh ? ram_rdata : r_word;
    assign w_bit_sel  = r_idx[BIT_W-1:0];
    assign w_setting  = (r_cmd == pfbt_pkg::CMD_LOCK) || (r_cmd == pfbt_pkg::CMD_RESERVE);
    assign w_flip     = w_word[w_bit_sel] != w_setting;
    assign w_idx_next = r_idx + (IDX_W + 1)'(1);
    assign w_last     = r_left == COUNT_W'(1);
    assign w_next_oor = w_idx_next >= LIMIT_IDX;
    assign w_row_end  = &r_idx[BIT_W-1:0];

    // Page indices only grow during a walk, so the first page beyond the map ends it.
    assign w_walk_end = w_last || w_next_oor;

    always_comb begin
        w_new_word            = w_word;
        w_new_word[w_bit_sel] = w_setting;
    end

    // Counter and result updates for the current cycle.
    always_comb begin
        n_free    = r_free;
        n_used    = r_used;
        n_res     = r_res;
        n_changed = r_changed;
        n_oor     = r_oor;
        unique case (r_state)
            ST_IDLE: begin
                n_changed = '0;
                n_oor     = !w_cnt_zero && w_first_oor;
            end
            ST_WALK: begin
                n_changed = r_changed + COUNT_W'(w_flip);
                n_oor     = w_next_oor && !w_last;
                if (w_flip) begin
                    unique case (r_cmd)
                        pfbt_pkg::CMD_FREE: begin
                            n_free = r_free + CNT_W'(1);
                            n_used = r_used - CNT_W'(1);
                        end
                        pfbt_pkg::CMD_LOCK: begin
                            n_free = r_free - CNT_W'(1);
                            n_used = r_used + CNT_W'(1);
                        end
                        pfbt_pkg::CMD_UNRESERVE: begin
                            n_free = r_free + CNT_W'(1);
                            n_res  = r_res - CNT_W'(1);
                        end
                        pfbt_pkg::CMD_RESERVE: begin
                            n_free = r_free - CNT_W'(1);
                            n_res  = r_res + CNT_W'(1);
                        end
                    endcase
                end
            end
            ST_CLEAR, ST_DONE: begin
            end
        endcase
    end

    // A response is ready when a trivial request is accepted, when a walk ends, or
    // while one waits in DONE. It goes to the output register once that is free.
    assign w_fin = (w_accept && (w_cnt_zero || w_first_oor))
                || ((r_state == ST_WALK) && w_walk_end)
                || (r_state == ST_DONE);
    assign w_slot_free = !r_rsp_valid || !i_rsp_stall;

    always_comb begin
        w_fin_rsp.free_pages     = n_free;
        w_fin_rsp.used_pages     = n_used;
        w_fin_rsp.reserved_pages = n_res;
        w_fin_rsp.pages_changed  = n_changed;
        w_fin_rsp.out_of_range   = n_oor;
    end

    // Map RAM access. The clearing pass owns the write port after reset. During a
    // walk a row is written back when the walk leaves it or ends, and the next row
    // is read in the same cycle; those two rows differ when the walk leaves a row.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx[IDX_W-1:BIT_W];
        ram_wdata = w_new_word;
        ram_raddr = w_idx_next[IDX_W-1:BIT_W];
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_row;
                ram_wdata = '0;
            end
            ST_IDLE: begin
                ram_raddr = w_first[IDX_W-1:BIT_W];
            end
            ST_WALK: begin
                ram_we = w_walk_end || w_row_end;
            end
            ST_DONE: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_row   <= '0;
            r_free      <= '0;
            r_used      <= '0;
            r_res       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            // Writing the total-pages register loads the free counter.
            if (i_cfg_we) begin
                r_free <= {{(CNT_W - pfbt_pkg::CFG_W){1'b0}}, i_cfg_data};
            end else begin
                r_free <= n_free;
            end
            r_used    <= n_used;
            r_res     <= n_res;
            r_changed <= n_changed;
            r_oor     <= n_oor;

            // The output register stays full while its response is stalled and
            // is refilled in the same cycle that the downstream side drains it.
            r_rsp_valid <= (w_fin && w_slot_free) || (r_rsp_valid && i_rsp_stall);
            if (w_fin && w_slot_free) begin
                r_rsp <= w_fin_rsp;
            end

            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_row <= r_clr_row + ROW_W'(1);
                    if (r_clr_row == LAST_ROW) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_accept) begin
                        r_cmd   <= pfbt_pkg::t_cmd'(i_req.command);
                        r_left  <= i_req.page_count;
                        r_idx   <= {1'b0, w_first[IDX_W-1:0]};
                        r_fresh <= 1'b1;
                        if (w_cnt_zero || w_first_oor) begin
                            r_state <= w_slot_free ? ST_IDLE : ST_DONE;
                        end else begin
                            r_state <= ST_WALK;
                        end
                    end
                end
                ST_WALK: begin
                    r_word  <= w_new_word;
                    r_left  <= r_left - COUNT_W'(1);
                    r_idx   <= w_idx_next;
                    r_fresh <= w_row_end;
                    if (w_walk_end) begin
                        r_state <= w_slot_free ? ST_IDLE : ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_slot_free) begin
                        r_state <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // Every flipped page moves one unit between two counters, so the sum of the
    // three counters changes only through a total-pages write or a reset.
    assign w_sum = r_free + r_used + r_res;

    `PFBT_ASSERT_IMPLY(a_walk_in_map, r_state == ST_WALK, r_idx < LIMIT_IDX, "walk past map")
    `PFBT_ASSERT_IMPLY(a_walk_has_pages, r_state == ST_WALK, r_left != '0, "walk with no pages")
    `PFBT_ASSERT_NEXT(a_sum_kept, !i_cfg_we, $stable(w_sum), "counter sum changed")

endmodule
